// ----- rtl/scd_pkg.sv -----
// scd_pkg: shared widths, constants and pipeline beat types for the
// serial clock divisor search; no dependencies
package scd_pkg;

  localparam int TW  = 22;   // target / achieved rate width
  localparam int CW  = 30;   // reference clock width
  localparam int AW  = 2;
  localparam int BW  = 6;
  localparam int NA  = 4;    // first stage choices
  localparam int NB  = 64;   // second stage choices
  localparam int MW  = 27;   // 22 * target
  localparam int DW  = 29;   // 22 * target * (a+1) - 1
  localparam int RDW = 13;   // 22 * (a+1) * (b+1)
  localparam int XW  = 36;   // range check compare width

  localparam int STAGE_FACTOR = 22;
  localparam int HI_FACTOR    = STAGE_FACTOR * (NA * NB + 1);
  localparam logic [CW-1:0] CLOCK_RESET = CW'(100000000);

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [TW-1:0] t;
    logic [CW-1:0] clk;
    logic          err;
  } item_t;

  typedef struct packed {
    logic          v;
    item_t         it;
    logic [MW-1:0] m22;
  } pbeat_t;

  typedef struct packed {
    logic [DW-1:0] den;
    logic          feas;
    logic [BW-1:0] b;
    logic [CW-1:0] rem;
  } blane_t;

  typedef blane_t [NA-1:0] blane_vec_t;

  typedef struct packed {
    logic       v;
    item_t      it;
    blane_vec_t ln;
  } bbeat_t;

  typedef struct packed {
    logic           feas;
    logic [BW-1:0]  b;
    logic [RDW-1:0] d;
    logic [TW-1:0]  q;
    logic [CW-1:0]  rem;
  } rlane_t;

  typedef rlane_t [NA-1:0] rlane_vec_t;

  typedef struct packed {
    logic       v;
    item_t      it;
    rlane_vec_t ln;
  } rbeat_t;

  typedef struct packed {
    logic          v;
    logic          status;
    logic [AW-1:0] a;
    logic [BW-1:0] b;
    logic [TW-1:0] rate;
  } obeat_t;

endpackage

// ----- rtl/scd_if.sv -----
// scd_if: valid/ready channel interfaces for target beats and result beats
// depends on scd_pkg for field widths
interface scd_in_if;
  logic                     valid;
  logic                     ready;
  logic [scd_pkg::TW-1:0]   target_scl_hz;

  modport source (output valid, output target_scl_hz, input ready);
  modport sink   (input valid, input target_scl_hz, output ready);
endinterface

interface scd_out_if;
  logic                     valid;
  logic                     ready;
  logic                     status;
  logic [scd_pkg::AW-1:0]   stage1_div;
  logic [scd_pkg::BW-1:0]   stage2_div;
  logic [scd_pkg::TW-1:0]   achieved_scl_hz;

  modport source (output valid, output status, output stage1_div, output stage2_div,
                  output achieved_scl_hz, input ready);
  modport sink   (input valid, input status, input stage1_div, input stage2_div,
                  input achieved_scl_hz, output ready);
endinterface

// ----- rtl/scd_prep.sv -----
// scd_prep: range check and per-lane divisor setup, two register stages
// depends on scd_pkg
module scd_prep (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_v,
  input  logic [scd_pkg::TW-1:0] in_t,
  input  logic [scd_pkg::CW-1:0] clk_hz,
  output scd_pkg::bbeat_t        bo
);
  import scd_pkg::*;

  pbeat_t p_r, p_nxt;
  bbeat_t b_r, b_nxt;

  // stage 1: 22 * target and range check
  always_comb begin
    logic lo, hi;
    p_nxt.v      = in_v;
    p_nxt.it.t   = in_t;
    p_nxt.it.clk = clk_hz;
    p_nxt.m22    = MW'(MW'(in_t) * MW'(STAGE_FACTOR));
    lo = XW'(clk_hz) < XW'(p_nxt.m22);
    hi = XW'(clk_hz) >= XW'(XW'(in_t) * XW'(HI_FACTOR));
    p_nxt.it.err = (in_t == '0) | lo | hi;
  end

  // stage 2: denominators, b range test, remainder seed
  always_comb begin
    b_nxt.v  = p_r.v;
    b_nxt.it = p_r.it;
    for (int l = 0; l < NA; l++) begin
      b_nxt.ln[l].den  = DW'(DW'(p_r.m22) * DW'(l + 1)) - DW'(1);
      b_nxt.ln[l].feas = (XW'(p_r.it.clk) + XW'(NB))
                         <= (XW'(XW'(p_r.m22) * XW'(l + 1)) << BW);
      b_nxt.ln[l].b    = '0;
      b_nxt.ln[l].rem  = p_r.it.clk - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r.v <= 1'b0;
      b_r.v <= 1'b0;
    end else if (adv) begin
      p_r <= p_nxt;
      b_r <= b_nxt;
    end
  end

  assign bo = b_r;
endmodule

// ----- rtl/scd_bdiv.sv -----
// scd_bdiv: restoring quotient of (clk-1)/den for four lanes, one bit a stage
// depends on scd_pkg
module scd_bdiv (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  scd_pkg::bbeat_t bi,
  output scd_pkg::bbeat_t bo
);
  import scd_pkg::*;

  bbeat_t st_r   [BW];
  bbeat_t st_nxt [BW];
  bbeat_t st_in  [BW];

  for (genvar k = 0; k < BW; k++) begin : g_step
    if (k == 0) begin : g_first
      assign st_in[k] = bi;
    end else begin : g_next
      assign st_in[k] = st_r[k-1];
    end

    always_comb begin
      logic [DW+BW-1:0] sh;
      st_nxt[k] = st_in[k];
      for (int l = 0; l < NA; l++) begin
        sh = (DW+BW)'(st_in[k].ln[l].den) << (BW - 1 - k);
        if ((DW+BW)'(st_in[k].ln[l].rem) >= sh) begin
          st_nxt[k].ln[l].rem = CW'((DW+BW)'(st_in[k].ln[l].rem) - sh);
          st_nxt[k].ln[l].b[BW-1-k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].v <= 1'b0;
      end else if (adv) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign bo = st_r[BW-1];
endmodule

// ----- rtl/scd_rdiv.sv -----
// scd_rdiv: achieved rate clk / (22*(a+1)*(b+1)) per lane, one quotient bit a stage
// depends on scd_pkg
module scd_rdiv (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  scd_pkg::bbeat_t bi,
  output scd_pkg::rbeat_t ro
);
  import scd_pkg::*;

  rbeat_t d_r, d_nxt;
  rbeat_t st_r   [TW];
  rbeat_t st_nxt [TW];
  rbeat_t st_in  [TW];

  // full divisor per lane
  always_comb begin
    d_nxt.v  = bi.v;
    d_nxt.it = bi.it;
    for (int l = 0; l < NA; l++) begin
      d_nxt.ln[l].feas = bi.ln[l].feas;
      d_nxt.ln[l].b    = bi.ln[l].b;
      d_nxt.ln[l].d    = RDW'((RDW'(bi.ln[l].b) + RDW'(1))
                              * RDW'(STAGE_FACTOR * (l + 1)));
      d_nxt.ln[l].q    = '0;
      d_nxt.ln[l].rem  = bi.it.clk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.v <= 1'b0;
    end else if (adv) begin
      d_r <= d_nxt;
    end
  end

  for (genvar k = 0; k < TW; k++) begin : g_step
    if (k == 0) begin : g_first
      assign st_in[k] = d_r;
    end else begin : g_next
      assign st_in[k] = st_r[k-1];
    end

    always_comb begin
      logic [RDW+TW-1:0] sh;
      st_nxt[k] = st_in[k];
      for (int l = 0; l < NA; l++) begin
        sh = (RDW+TW)'(st_in[k].ln[l].d) << (TW - 1 - k);
        if ((RDW+TW)'(st_in[k].ln[l].rem) >= sh) begin
          st_nxt[k].ln[l].rem = CW'((RDW+TW)'(st_in[k].ln[l].rem) - sh);
          st_nxt[k].ln[l].q[TW-1-k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].v <= 1'b0;
      end else if (adv) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign ro = st_r[TW-1];
endmodule

// ----- rtl/scd_pick.sv -----
// scd_pick: best-candidate selection and the output register
// depends on scd_pkg
module scd_pick (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  scd_pkg::rbeat_t ri,
  output scd_pkg::obeat_t oo
);
  import scd_pkg::*;

  obeat_t o_r, o_nxt;

  always_comb begin
    logic          found;
    logic [AW-1:0] ba;
    logic [BW-1:0] bb;
    logic [TW-1:0] br;
    found = 1'b0;
    ba    = '0;
    bb    = '0;
    br    = ri.it.t;
    // least error is the highest rate not above target; lower a wins ties
    for (int l = 0; l < NA; l++) begin
      if (ri.ln[l].feas && (ri.ln[l].q <= ri.it.t) && (!found || ri.ln[l].q > br)) begin
        found = 1'b1;
        ba    = AW'(l);
        bb    = ri.ln[l].b;
        br    = ri.ln[l].q;
      end
    end
    o_nxt.v = ri.v;
    if (ri.it.err) begin
      o_nxt.status = STATUS_ERR;
      o_nxt.a      = '0;
      o_nxt.b      = '0;
      o_nxt.rate   = '0;
    end else begin
      o_nxt.status = STATUS_OK;
      o_nxt.a      = ba;
      o_nxt.b      = bb;
      o_nxt.rate   = br;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_r.v <= 1'b0;
    end else if (adv) begin
      o_r <= o_nxt;
    end
  end

  assign oo = o_r;
endmodule

// ----- rtl/scl_clock_divisor_search.sv -----
// scl_clock_divisor_search: top level of the serial clock divisor search
// depends on scd_pkg, scd_if, scd_prep, scd_bdiv, scd_rdiv, scd_pick
//
//   channel   dir   beat contents                              handshake
//   in_if     in    target_scl_hz                              valid/ready
//   out_if    out   status, stage1_div, stage2_div, achieved   valid/ready
//   cfg_*     in    input_clock_hz                             write enable
//
// one target beat a cycle unless the output stalls; a beat passes through
// 2 setup stages, 6 b-quotient stages, a divisor stage, 22 rate-quotient
// stages and the output register, most of them the bit-per-stage dividers
// reset is synchronous active low, clears the valid bits and loads the
// reference clock with 100000000
// the whole pipeline holds while the output beat waits, so in_ready
// follows out ready whenever the output register is full
module scl_clock_divisor_search (
  input  logic                   clk,
  input  logic                   rst_n,
  scd_in_if.sink                 in_if,
  scd_out_if.source              out_if,
  input  logic                   cfg_we,
  input  logic [scd_pkg::CW-1:0] cfg_wdata
);
  import scd_pkg::*;

  logic [CW-1:0] cfg_clk_r;
  logic          adv;
  bbeat_t        prep_bo;
  bbeat_t        bdiv_bo;
  rbeat_t        rdiv_ro;
  obeat_t        pick_oo;

  // reference clock register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_clk_r <= CLOCK_RESET;
    end else if (cfg_we) begin
      cfg_clk_r <= cfg_wdata;
    end
  end

  // global advance: moves when the output slot is free or being taken
  assign adv         = !pick_oo.v || out_if.ready;
  assign in_if.ready = adv;

  scd_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_v   (in_if.valid),
    .in_t   (in_if.target_scl_hz),
    .clk_hz (cfg_clk_r),
    .bo     (prep_bo)
  );

  // b+1 = ceil(clk/den) via floor((clk-1)/den)
  scd_bdiv u_bdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .bi    (prep_bo),
    .bo    (bdiv_bo)
  );

  scd_rdiv u_rdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .bi    (bdiv_bo),
    .ro    (rdiv_ro)
  );

  scd_pick u_pick (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ri    (rdiv_ro),
    .oo    (pick_oo)
  );

  assign out_if.valid           = pick_oo.v;
  assign out_if.status          = pick_oo.status;
  assign out_if.stage1_div      = pick_oo.a;
  assign out_if.stage2_div      = pick_oo.b;
  assign out_if.achieved_scl_hz = pick_oo.rate;
endmodule

// ----- rtl/scd_checker.sv -----
// scd_checker: port-level assertions for the divisor search, bound to the top
// depends on scd_pkg and scl_clock_divisor_search
module scd_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_status,
  input logic [scd_pkg::AW-1:0] out_a,
  input logic [scd_pkg::BW-1:0] out_b,
  input logic [scd_pkg::TW-1:0] out_rate
);
  import scd_pkg::*;

  // error beats carry zero divisors and rate
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_ERR |-> out_a == '0 && out_b == '0 && out_rate == '0)
    else $error("error beat with nonzero fields");

  // input side stalls exactly when a result waits
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in ready does not follow output slot");

  // no result right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_a)
      && $stable(out_b) && $stable(out_rate))
    else $error("result changed while stalled");
endmodule

bind scl_clock_divisor_search scd_checker u_scd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_status (out_if.status),
  .out_a      (out_if.stage1_div),
  .out_b      (out_if.stage2_div),
  .out_rate   (out_if.achieved_scl_hz)
);

// ----- sim/scd_tb_if.sv -----
// scd_tb_if: testbench channel interfaces are the rtl ones in rtl/scd_if.sv
// this file holds the beat record used between stimulus and checker
// depends on scd_pkg
package scd_tb_pkg;
  import scd_pkg::*;

  typedef struct packed {
    logic          status;
    logic [AW-1:0] a;
    logic [BW-1:0] b;
    logic [TW-1:0] rate;
  } divisor_res_t;
endpackage

// ----- sim/scd_checker.sv -----
// scd_scoreboard: watches target and result beats, predicts divisors, compares
// depends on scd_pkg, scd_tb_pkg and the scd_in_if / scd_out_if interfaces
module scd_scoreboard (
  input  logic                   clk,
  input  logic                   rst_n,
  scd_in_if                      in_if,
  scd_out_if                     out_if,
  input  logic                   cfg_we,
  input  logic [scd_pkg::CW-1:0] cfg_wdata,
  output int                     fail_count,
  output int                     pending,
  output int                     results_seen
);
  import scd_pkg::*;
  import scd_tb_pkg::*;

  logic [CW-1:0] ref_clock_hz;
  divisor_res_t  expected_q[$];

  function automatic divisor_res_t search_divisors(logic [TW-1:0] target,
                                                   logic [CW-1:0] refclk);
    divisor_res_t r;
    longint unsigned q, den, bp1, rate, err, best_err;
    r = '0;
    r.status = STATUS_ERR;
    if (target == 0) return r;
    q = longint'(refclk) / (longint'(STAGE_FACTOR) * target);
    if (q == 0 || q > NA * NB) return r;
    r.status = STATUS_OK;
    r.rate = target;
    best_err = '1;
    for (int a = 0; a < NA; a++) begin
      den = longint'(STAGE_FACTOR) * target * (a + 1) - 1;
      bp1 = (longint'(refclk) + den - 1) / den;
      if (bp1 < 1 || bp1 > NB) continue;
      rate = longint'(refclk) / (longint'(STAGE_FACTOR) * (a + 1) * bp1);
      if (rate > target) continue;
      err = target - rate;
      if (err < best_err) begin
        best_err = err;
        r.a = a[AW-1:0];
        r.b = BW'(bp1 - 1);
        r.rate = rate[TW-1:0];
      end
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    divisor_res_t e;
    if (!rst_n) begin
      ref_clock_hz <= CLOCK_RESET;
      fail_count   <= 0;
      results_seen <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we) ref_clock_hz <= cfg_wdata;
      if (in_if.valid && in_if.ready)
        expected_q.push_back(search_divisors(in_if.target_scl_hz, ref_clock_hz));
      if (out_if.valid && out_if.ready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_if.status !== e.status || out_if.stage1_div !== e.a ||
              out_if.stage2_div !== e.b || out_if.achieved_scl_hz !== e.rate) begin
            if (out_if.status !== e.status)
              $error("status: expected %0d, got %0d", e.status, out_if.status);
            if (out_if.stage1_div !== e.a)
              $error("stage1_div: expected %0d, got %0d", e.a, out_if.stage1_div);
            if (out_if.stage2_div !== e.b)
              $error("stage2_div: expected %0d, got %0d", e.b, out_if.stage2_div);
            if (out_if.achieved_scl_hz !== e.rate)
              $error("achieved_scl_hz: expected %0d, got %0d", e.rate,
                     out_if.achieved_scl_hz);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- sim/tb_scl_clock_divisor_search.sv -----
// tb_scl_clock_divisor_search: stimulus and verdict for the divisor search
// depends on scd_pkg, rtl interfaces, scd_scoreboard and the block itself
module tb_scl_clock_divisor_search;
  import scd_pkg::*;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [CW-1:0] cfg_wdata;
  int            fail_count, pending, results_seen;
  int            src_idle_pct, snk_stall_pct;
  int            beats_sent;

  scd_in_if  in_if ();
  scd_out_if out_if ();

  scl_clock_divisor_search i_dut (
    .clk, .rst_n, .in_if(in_if.sink), .out_if(out_if.source), .cfg_we, .cfg_wdata
  );

  scd_scoreboard i_chk (
    .clk, .rst_n, .in_if, .out_if, .cfg_we, .cfg_wdata,
    .fail_count, .pending, .results_seen
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // receiver stalls at random, changed on the falling edge
  always @(negedge clk)
    out_if.ready <= ($urandom_range(99) >= snk_stall_pct);

  // one target beat: optional idle gap, then hold valid until accepted
  task automatic send_target(logic [TW-1:0] t);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.target_scl_hz <= t;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  // drain the pipeline, then write the reference clock while idle
  task automatic set_ref_clock(logic [CW-1:0] hz);
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= hz;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // target drawn mostly from the useful range for the current clock
  function automatic logic [TW-1:0] pick_target(logic [CW-1:0] refclk);
    longint unsigned lo, hi;
    case ($urandom_range(9))
      0: return TW'($urandom);
      1: return TW'($urandom_range(4000000, 1));
      2: return TW'($urandom_range(3));
      default: begin
        lo = refclk / (22 * 257) + 1;
        hi = refclk / 22;
        if (hi > 4194303) hi = 4194303;
        if (hi < lo) return TW'($urandom_range(4000000, 1));
        return TW'($urandom_range(int'(hi), int'(lo)));
      end
    endcase
  endfunction

  logic [CW-1:0] clocks[8];
  int            idle_tab[4][2];

  initial begin
    clocks = '{30'd100000000, 30'd1000000000, 30'd1, 30'd0, 30'h3fffffff,
               30'd24000000, 30'd133333333, 30'd5000};
    idle_tab = '{'{0, 0}, '{69, 0}, '{0, 69}, '{15, 15}};
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    in_if.valid = 1'b0; in_if.target_scl_hz = '0; out_if.ready = 1'b0;
    src_idle_pct = 0; snk_stall_pct = 0; beats_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset clock, field extremes, zero target, range edges
    send_target(TW'(0));
    send_target(TW'(1));
    send_target(TW'(4194303));  // q becomes 1
    send_target(TW'(4000000));
    send_target(TW'(100000));
    send_target(TW'(400000));
    send_target(TW'(17714));    // near q upper bound for reset clock
    send_target(TW'(17683));    // just out of range low side
    send_target(TW'(17686));    // last target with q above 256
    send_target(TW'(17687));    // first target with q at 256
    send_target(TW'(1 << 21));
    send_target(TW'(21'h155555));
    send_target(TW'(22'h2aaaaa));

    // random phases: sweep clocks and idle patterns
    for (int ph = 0; ph < 16; ph++) begin
      logic [CW-1:0] rc;
      rc = (ph < 8) ? clocks[ph] : CW'($urandom_range(1000000000, 1));
      set_ref_clock(rc);
      src_idle_pct  = idle_tab[ph % 4][0];
      snk_stall_pct = idle_tab[ph % 4][1];
      for (int i = 0; i < 112; i++) send_target(pick_target(rc));
    end
    set_ref_clock(30'd100000000);

    in_if.valid <= 1'b0;
    snk_stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("covered %0d target beats and %0d result beats over 17 clock settings",
             beats_sent, results_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/scd_pkg.sv
rtl/scd_if.sv
rtl/scd_prep.sv
rtl/scd_bdiv.sv
rtl/scd_rdiv.sv
rtl/scd_pick.sv
rtl/scl_clock_divisor_search.sv
rtl/scd_checker.sv
sim/scd_tb_if.sv
sim/scd_checker.sv
sim/tb_scl_clock_divisor_search.sv
